@@ design/lgsm_pkg.sv @@
// Types, constants and codes shared by the light gate array speed meter.
// No dependencies; every other file of the block imports this package.
package lgsm_pkg;

  localparam int NUM_SENSORS  = 4;
  localparam int SAMPLE_BITS  = 10;
  localparam int SENSOR_IDX_W = $clog2(NUM_SENSORS);
  localparam int TIME_W       = 32;
  localparam int SAMPLES_W    = 40;
  localparam int THR_W        = 12;
  localparam int MARGIN_W     = 10;
  localparam int LIMIT_W      = 10;
  localparam int SPACING_W    = 16;
  localparam int SCALE_W      = 10;
  localparam int SPEED_W      = 26;
  localparam int OPCODE_W     = 2;
  localparam int STATUS_W     = 3;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_DATA_W    = 72;
  localparam int OUT_DATA_W   = 72;

  // mm/s from mm per ms
  localparam logic [SCALE_W-1:0] MS_PER_S  = SCALE_W'(1000);
  localparam logic [SPEED_W-1:0] SPEED_SAT = SPEED_W'(65535000);

  typedef enum logic [OPCODE_W-1:0] {
    OPC_MEASURE = 2'd0,
    OPC_CALIB   = 2'd1,
    OPC_CLEAR   = 2'd2,
    OPC_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_NONE  = 3'd0,
    STAT_ONE   = 3'd1,
    STAT_MULTI = 3'd2,
    STAT_CAL   = 3'd3,
    STAT_WARN  = 3'd4
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MARGIN  = 2'd0,
    REG_LIMIT   = 2'd1,
    REG_SPACING = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    BK_IDLE,
    BK_DIV
  } bk_state_t;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    opcode_t                       op;
    logic [TIME_W-1:0]             time_ms;
    sample_t [NUM_SENSORS-1:0]     smp;
  } item_t;

  typedef struct packed {
    logic [MARGIN_W-1:0]  margin;
    logic [LIMIT_W-1:0]   limit;
    logic [SPACING_W-1:0] spacing;
  } cfg_t;

  typedef struct packed {
    status_t                   status;
    logic [SENSOR_IDX_W-1:0]   sensor_index;
    logic [NUM_SENSORS-1:0]    detect_mask;
    logic                      new_speed;
    logic [TIME_W-1:0]         interval_ms;
    logic [SPEED_W-1:0]        speed_mm_s;
  } result_t;

endpackage

@@ design/lgsm_front.sv @@
// Front end: takes input words, classifies the opcode, splits the samples
// and queues decoded items for the back end. Depends on lgsm_pkg.
module lgsm_front import lgsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OPCODE_W-1:0]  in_opcode,
  input  logic [TIME_W-1:0]    in_time_ms,
  input  logic [SAMPLES_W-1:0] in_samples,
  output logic                 q_valid,
  input  logic                 q_pop,
  output item_t                q_item
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  item_t               item_in;
  item_t               q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;

  always_comb begin
    item_in.op      = opcode_t'(in_opcode);
    item_in.time_ms = in_time_ms;
    for (int s = 0; s < NUM_SENSORS; s++) begin
      item_in.smp[s] = in_samples[s*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  assign in_ready = (count_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

@@ design/lgsm_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, for the speed
// figure (spacing * 1000 / interval). Depends on lgsm_pkg.
module lgsm_div import lgsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SPEED_W-1:0] dividend,
  input  logic [TIME_W-1:0]  divisor,
  output logic               done,
  output logic [SPEED_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SPEED_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SPEED_W - 1);

  logic [TIME_W-1:0]  rem_r, rem_nxt;
  logic [SPEED_W-1:0] quo_r, quo_nxt;
  logic [TIME_W-1:0]  dvs_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [TIME_W:0]    trial;
  logic [TIME_W:0]    diff;
  logic               ge;

  always_comb begin
    trial = {rem_r, quo_r[SPEED_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top bit is always clear
      rem_nxt = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      quo_nxt = {quo_r[SPEED_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ design/lgsm_back.sv @@
// Back end: holds thresholds and timing state, executes queued items,
// drives the divider and the output register. Depends on lgsm_pkg, lgsm_div.
module lgsm_back import lgsm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    q_valid,
  output logic    q_pop,
  input  item_t   q_item,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  bk_state_t                     state_r, state_nxt;
  logic signed [THR_W-1:0]       thr_r [NUM_SENSORS];
  logic signed [THR_W-1:0]       thr_nxt [NUM_SENSORS];
  logic signed [THR_W-1:0]       thr_cal [NUM_SENSORS];
  logic [SENSOR_IDX_W-1:0]       prev_r, prev_nxt;
  logic [TIME_W-1:0]             last_time_r, last_time_nxt;
  logic [SPEED_W-1:0]            speed_r, speed_nxt;
  logic                          out_valid_r, out_valid_nxt;
  result_t                       out_r, out_nxt;
  result_t                       pend_r, pend_nxt;
  result_t                       res;

  logic                          out_free;
  logic                          issue;
  logic                          need_div;
  logic                          warn;
  logic [NUM_SENSORS-1:0]        mask;
  logic                          multi;
  logic [SENSOR_IDX_W-1:0]       first;
  logic [TIME_W-1:0]             interval;
  logic [SPEED_W-1:0]            dividend;
  logic                          div_done;
  logic [SPEED_W-1:0]            quotient;
  logic signed [THR_W:0]         diff;
  logic [THR_W:0]                diff_abs;

  assign out_free = !out_valid_r || out_ready;
  assign issue    = (state_r == BK_IDLE) && q_valid && out_free;
  assign q_pop    = issue;

  // per-sensor classification of the head item
  always_comb begin
    warn  = 1'b0;
    mask  = '0;
    first = '0;
    diff     = '0;
    diff_abs = '0;
    for (int s = 0; s < NUM_SENSORS; s++) begin
      thr_cal[s] = $signed({{(THR_W-SAMPLE_BITS){1'b0}}, q_item.smp[s]})
                 - $signed({{(THR_W-MARGIN_W){1'b0}}, cfg.margin});
      mask[s] = $signed({{(THR_W-SAMPLE_BITS){1'b0}}, q_item.smp[s]}) < thr_r[s];
    end
    for (int s = 1; s < NUM_SENSORS; s++) begin
      diff     = {thr_cal[s][THR_W-1], thr_cal[s]} - {thr_cal[s-1][THR_W-1], thr_cal[s-1]};
      diff_abs = diff[THR_W] ? -diff : diff;
      if (diff_abs > {{(THR_W+1-LIMIT_W){1'b0}}, cfg.limit}) begin
        warn = 1'b1;
      end
    end
    for (int s = NUM_SENSORS - 1; s >= 0; s--) begin
      if (mask[s]) begin
        first = SENSOR_IDX_W'(s);
      end
    end
    multi    = (mask & (mask - 1'b1)) != '0;
    interval = q_item.time_ms - last_time_r;
    dividend = cfg.spacing * MS_PER_S;
  end

  assign need_div = issue && (q_item.op == OPC_MEASURE) && (mask != '0) && !multi
                  && (first != prev_r) && (interval != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (need_div) state_nxt = BK_DIV;
      BK_DIV:  if (div_done) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    thr_nxt       = thr_r;
    prev_nxt      = prev_r;
    last_time_nxt = last_time_r;
    speed_nxt     = speed_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    res           = '0;
    res.status    = STAT_NONE;
    res.speed_mm_s = speed_r;

    if (issue) begin
      unique case (q_item.op)
        OPC_CALIB: begin
          thr_nxt    = thr_cal;
          res.status = warn ? STAT_WARN : STAT_CAL;
        end
        OPC_CLEAR: begin
          last_time_nxt  = '0;
          speed_nxt      = '0;
          res.speed_mm_s = '0;
        end
        OPC_MEASURE: begin
          res.detect_mask = mask;
          if (mask != '0) begin
            res.sensor_index = first;
            res.status       = multi ? STAT_MULTI : STAT_ONE;
            if (!multi) begin
              prev_nxt = first;
              if (first != prev_r) begin
                res.new_speed    = 1'b1;
                res.interval_ms  = interval;
                last_time_nxt    = q_item.time_ms;
                // the sensor just left gets a fresh threshold from this word
                thr_nxt[prev_r]  = thr_cal[prev_r];
                if (interval == '0) begin
                  speed_nxt      = SPEED_SAT;
                  res.speed_mm_s = SPEED_SAT;
                end
              end
            end
          end
        end
        OPC_NONE: begin
        end
        default: begin
        end
      endcase
      if (need_div) begin
        pend_nxt = res;
      end else begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end
    end

    if (div_done) begin
      speed_nxt          = quotient;
      out_nxt            = pend_r;
      out_nxt.speed_mm_s = quotient;
      out_valid_nxt      = 1'b1;
    end
  end

  lgsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (need_div),
    .dividend (dividend),
    .divisor  (interval),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      prev_r      <= '0;
      last_time_r <= '0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < NUM_SENSORS; s++) begin
        thr_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      last_time_r <= last_time_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r       <= thr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_div_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> !out_valid_r)
    else $error("output register busy during division");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == BK_DIV)
    else $error("divider finished outside division state");

  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid_r || out_ready) && q_valid)
    else $error("item popped without room for its result");

  a_new_speed_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.new_speed |-> out_r.status == STAT_ONE)
    else $error("new speed flagged on a result that is not a single detection");

endmodule

@@ design/light_gate_array_speed_meter.sv @@
// Light gate array speed meter: four light sensors, calibrate / measure /
// clear words, one result word per input word. A measure word whose single
// dimmed sensor differs from the previous one, with a non-zero interval, needs
// a division; that word is issued to the back end and then passes through a
// 26-step radix-2 divider for spacing * 1000 / interval before its result is
// registered. Every other word has its result registered as it issues. A
// two-entry queue behind the input lets words arrive while a division runs or
// a result waits, and the output register is refilled in the cycle its word
// is taken.
// Depends on lgsm_pkg, lgsm_front, lgsm_back.
module light_gate_array_speed_meter import lgsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // time_ms[31:0], samples[71:32]
  input  logic [OPCODE_W-1:0]   in_tuser,   // opcode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // sensor_index[1:0], detect_mask[5:2],
                                            // new_speed[6], interval_ms[38:7],
                                            // speed_mm_s[64:39], zero [71:65]
  output logic [STATUS_W-1:0]   out_tuser,  // status[2:0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RES_DATA_W = SENSOR_IDX_W + NUM_SENSORS + 1 + TIME_W + SPEED_W;

  cfg_t    cfg_r;
  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.margin  <= MARGIN_W'(100);
      cfg_r.limit   <= LIMIT_W'(50);
      cfg_r.spacing <= SPACING_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_MARGIN:  cfg_r.margin  <= cfg_data[MARGIN_W-1:0];
        REG_LIMIT:   cfg_r.limit   <= cfg_data[LIMIT_W-1:0];
        REG_SPACING: cfg_r.spacing <= cfg_data[SPACING_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lgsm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_opcode  (in_tuser),
    .in_time_ms (in_tdata[TIME_W-1:0]),
    .in_samples (in_tdata[TIME_W +: SAMPLES_W]),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  lgsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // result struct minus status, with sensor_index landing in the low bits
  logic [RES_DATA_W-1:0] res_fields;
  assign res_fields = {res.speed_mm_s, res.interval_ms, res.new_speed,
                       res.detect_mask, res.sensor_index};
  assign out_tdata  = {{(OUT_DATA_W-RES_DATA_W){1'b0}}, res_fields};
  assign out_tuser  = res.status;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the light gate array speed meter: queued stimulus, a
// word driver, a result monitor and a predictor kept in step with the block.
// Depends on lgsm_pkg and light_gate_array_speed_meter.
module testbench import lgsm_pkg::*; ();

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  typedef enum logic [1:0] {
    ENTRY_WORD,
    ENTRY_CFG,
    ENTRY_DRAIN
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t           kind;
    opcode_t               op;
    logic [TIME_W-1:0]     time_ms;
    logic [SAMPLES_W-1:0]  samples;
    cfg_reg_t              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
  } gate_entry_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // time_ms[31:0], samples[71:32]
  logic [OPCODE_W-1:0]   in_tuser = '0;   // opcode[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // sensor_index[1:0], detect_mask[5:2],
                                          // new_speed[6], interval_ms[38:7],
                                          // speed_mm_s[64:39]
  logic [STATUS_W-1:0]   out_tuser;       // status[2:0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gate_entry_t gate_words[$];
  gate_entry_t on_bus;
  result_t     readings_due[$];
  int          total_entries = 0;
  int          entries_done = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          draining = 1'b0;
  bit          calm = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;
  int          sweep_pos = 0;

  // predictor copy of the block's state and registers
  logic signed [THR_W-1:0] thr_now[NUM_SENSORS];
  logic [SENSOR_IDX_W-1:0] prev_dimmed;
  logic [TIME_W-1:0]       last_pass_ms;
  logic [SPEED_W-1:0]      speed_now;
  logic [MARGIN_W-1:0]     margin_cfg;
  logic [LIMIT_W-1:0]      limit_cfg;
  logic [SPACING_W-1:0]    spacing_cfg;

  light_gate_array_speed_meter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t predict_reading(opcode_t op, logic [TIME_W-1:0] t,
                                              logic [SAMPLES_W-1:0] smp);
    result_t     r;
    int          dimmed;
    int          first;
    int          d;
    logic        warn;
    logic [63:0] quot;
    r = '0;
    dimmed = 0;
    first = 0;
    warn = 1'b0;
    case (op)
      OPC_CALIB: begin
        for (int s = 0; s < NUM_SENSORS; s++) begin
          thr_now[s] = THR_W'(int'(smp[s*SAMPLE_BITS +: SAMPLE_BITS]) - int'(margin_cfg));
          if (s > 0) begin
            d = int'(thr_now[s]) - int'(thr_now[s-1]);
            if (d < 0) d = -d;
            if (d > int'(limit_cfg)) warn = 1'b1;
          end
        end
        r.status = warn ? STAT_WARN : STAT_CAL;
      end
      OPC_MEASURE: begin
        for (int s = 0; s < NUM_SENSORS; s++)
          if (int'(smp[s*SAMPLE_BITS +: SAMPLE_BITS]) < int'(thr_now[s])) begin
            if (dimmed == 0) first = s;
            dimmed++;
            r.detect_mask[s] = 1'b1;
          end
        if (dimmed > 1) begin
          r.status = STAT_MULTI;
          r.sensor_index = SENSOR_IDX_W'(first);
        end else if (dimmed == 1) begin
          r.status = STAT_ONE;
          r.sensor_index = SENSOR_IDX_W'(first);
          if (first != int'(prev_dimmed)) begin
            r.interval_ms = t - last_pass_ms;
            last_pass_ms = t;
            // the sensor just left is recalibrated from this word's sample
            thr_now[prev_dimmed] = THR_W'(int'(smp[prev_dimmed*SAMPLE_BITS +: SAMPLE_BITS])
                                          - int'(margin_cfg));
            if (r.interval_ms == '0) begin
              speed_now = SPEED_SAT;
            end else begin
              quot = (64'(spacing_cfg) * 64'd1000) / 64'(r.interval_ms);
              speed_now = quot[SPEED_W-1:0];
            end
            r.new_speed = 1'b1;
          end
          prev_dimmed = SENSOR_IDX_W'(first);
        end
      end
      OPC_CLEAR: begin
        last_pass_ms = '0;
        speed_now = '0;
      end
      default: ;
    endcase
    r.speed_mm_s = speed_now;
    return r;
  endfunction

  task automatic compare_reading(result_t want, result_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.sensor_index !== want.sensor_index) begin
      $error("sensor_index: expected %0d, got %0d", want.sensor_index, got.sensor_index);
      mismatches++;
    end
    if (got.detect_mask !== want.detect_mask) begin
      $error("detect_mask: expected %b, got %b", want.detect_mask, got.detect_mask);
      mismatches++;
    end
    if (got.new_speed !== want.new_speed) begin
      $error("new_speed: expected %0d, got %0d", want.new_speed, got.new_speed);
      mismatches++;
    end
    if (got.interval_ms !== want.interval_ms) begin
      $error("interval_ms: expected %0d, got %0d", want.interval_ms, got.interval_ms);
      mismatches++;
    end
    if (got.speed_mm_s !== want.speed_mm_s) begin
      $error("speed_mm_s: expected %0d, got %0d", want.speed_mm_s, got.speed_mm_s);
      mismatches++;
    end
  endtask

  // driver: words and register writes from the queue, prediction on acceptance
  always @(posedge clk) begin
    logic next_in_valid;
    logic next_cfg_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left = 0;
      draining = 1'b0;
      for (int s = 0; s < NUM_SENSORS; s++) thr_now[s] = '0;
      prev_dimmed = '0;
      last_pass_ms = '0;
      speed_now = '0;
      margin_cfg = MARGIN_W'(100);
      limit_cfg = LIMIT_W'(50);
      spacing_cfg = SPACING_W'(100);
    end else begin
      next_in_valid = in_tvalid;
      next_cfg_valid = cfg_valid;
      if (in_tvalid && in_tready) begin
        readings_due.push_back(predict_reading(on_bus.op, on_bus.time_ms, on_bus.samples));
        entries_done++;
        next_in_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (on_bus.cfg_idx)
          REG_MARGIN:  margin_cfg = on_bus.cfg_val[MARGIN_W-1:0];
          REG_LIMIT:   limit_cfg = on_bus.cfg_val[LIMIT_W-1:0];
          REG_SPACING: spacing_cfg = on_bus.cfg_val[SPACING_W-1:0];
          default: ;
        endcase
        entries_done++;
        next_cfg_valid = 1'b0;
      end
      if (draining && readings_due.size() == 0) begin
        draining = 1'b0;
        entries_done++;
      end
      if (!next_in_valid && !next_cfg_valid && !draining) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (gate_words.size() > 0) begin
          case (gate_words[0].kind)
            ENTRY_WORD: begin
              on_bus = gate_words.pop_front();
              in_tdata <= {on_bus.samples, on_bus.time_ms};
              in_tuser <= on_bus.op;
              next_in_valid = 1'b1;
              if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
            end
            ENTRY_CFG: begin
              // registers change only with nothing in flight
              if (readings_due.size() == 0) begin
                on_bus = gate_words.pop_front();
                cfg_addr <= on_bus.cfg_idx;
                cfg_data <= on_bus.cfg_val;
                next_cfg_valid = 1'b1;
              end
            end
            default: begin
              void'(gate_words.pop_front());
              draining = 1'b1;
            end
          endcase
        end
      end
      in_tvalid <= next_in_valid;
      cfg_valid <= next_cfg_valid;
    end
  end

  // monitor: take result words with random back-pressure and check them
  always @(posedge clk) begin
    result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.sensor_index = out_tdata[1:0];
        got.detect_mask = out_tdata[5:2];
        got.new_speed = out_tdata[6];
        got.interval_ms = out_tdata[38:7];
        got.speed_mm_s = out_tdata[64:39];
        if (readings_due.size() == 0) begin
          $error("result word with nothing outstanding: status %0d", got.status);
          mismatches++;
        end else begin
          compare_reading(readings_due.pop_front(), got);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_word(opcode_t op, logic [TIME_W-1:0] t, logic [SAMPLES_W-1:0] smp);
    gate_entry_t e;
    e = '0;
    e.kind = ENTRY_WORD;
    e.op = op;
    e.time_ms = t;
    e.samples = smp;
    gate_words.push_back(e);
    total_entries++;
  endtask

  task automatic push_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    gate_entry_t e;
    e = '0;
    e.kind = ENTRY_CFG;
    e.cfg_idx = idx;
    e.cfg_val = val;
    gate_words.push_back(e);
    total_entries++;
  endtask

  task automatic push_drain();
    gate_entry_t e;
    e = '0;
    e.kind = ENTRY_DRAIN;
    gate_words.push_back(e);
    total_entries++;
  endtask

  function automatic logic [SAMPLES_W-1:0] row4(int a, int b, int c, int d);
    return {SAMPLE_BITS'(d), SAMPLE_BITS'(c), SAMPLE_BITS'(b), SAMPLE_BITS'(a)};
  endfunction

  // dark sensors well below any working threshold, the rest bright
  function automatic logic [SAMPLES_W-1:0] dim_row(logic [NUM_SENSORS-1:0] dark);
    logic [SAMPLES_W-1:0] row;
    for (int s = 0; s < NUM_SENSORS; s++)
      row[s*SAMPLE_BITS +: SAMPLE_BITS] = dark[s] ? SAMPLE_BITS'($urandom_range(0, 600))
                                                  : SAMPLE_BITS'($urandom_range(950, 1023));
    return row;
  endfunction

  function automatic logic [SAMPLES_W-1:0] calib_row();
    return row4($urandom_range(850, 950), $urandom_range(850, 950),
                $urandom_range(850, 950), $urandom_range(850, 950));
  endfunction

  function automatic logic [SAMPLES_W-1:0] noise_row();
    return SAMPLES_W'({$urandom, $urandom});
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_cfg(int hi, int typ_lo, int typ_hi);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(hi);
      default: return CFG_DATA_W'($urandom_range(typ_lo, typ_hi));
    endcase
  endfunction

  task automatic advance_clock();
    case ($urandom_range(0, 19))
      0:       ;                          // same stamp: zero interval
      1:       clock_ms += $urandom;      // long jump, may wrap
      default: clock_ms += $urandom_range(1, 3000);
    endcase
  endtask

  // mostly a dark spot sweeping along the row, with noise and broken passes
  task automatic push_traffic(int count);
    int n;
    int pick;
    logic [NUM_SENSORS-1:0] dark;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_word(OPC_CALIB, clock_ms, ($urandom_range(0, 3) == 0) ? noise_row() : calib_row());
        n++;
      end else if (pick < 12) begin
        push_word(OPC_CLEAR, $urandom, noise_row());
        n++;
      end else if (pick < 15) begin
        push_word(OPC_NONE, $urandom, noise_row());
      end else if (pick < 22) begin
        push_word(OPC_MEASURE, $urandom, noise_row());
        n++;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) sweep_pos = (sweep_pos + 1) % NUM_SENSORS;
        else if (pick == 6) sweep_pos = (sweep_pos + NUM_SENSORS - 1) % NUM_SENSORS;
        else if (pick == 9) sweep_pos = $urandom_range(0, NUM_SENSORS - 1);
        dark = '0;
        dark[sweep_pos] = 1'b1;
        if ($urandom_range(0, 11) == 0) dark[$urandom_range(0, NUM_SENSORS - 1)] = 1'b1;
        if ($urandom_range(0, 15) == 0) dark = '0;
        advance_clock();
        push_word(OPC_MEASURE, clock_ms, dim_row(dark));
        n++;
      end
    end
  endtask

  initial begin
    // reset register values: nothing detected until calibrated
    push_word(OPC_MEASURE, '0, '0);
    push_word(OPC_NONE, $urandom, noise_row());
    push_word(OPC_CALIB, '0, row4(1023, 1023, 1023, 1023));
    push_word(OPC_CALIB, '0, row4(0, 1023, 0, 1023));
    push_word(OPC_CALIB, '0, row4(900, 900, 900, 900));
    push_word(OPC_MEASURE, 32'd200, dim_row(4'b0001));   // same sensor as the start
    push_word(OPC_MEASURE, 32'd1000, dim_row(4'b0010));
    push_word(OPC_MEASURE, 32'd1500, dim_row(4'b0010));
    push_word(OPC_MEASURE, 32'd1500, dim_row(4'b0100));
    push_word(OPC_MEASURE, 32'd1500, dim_row(4'b1000));  // zero interval
    push_word(OPC_MEASURE, 32'd1600, dim_row(4'b1010));
    push_word(OPC_MEASURE, 32'd1700, dim_row(4'b0000));
    push_word(OPC_MEASURE, 32'd100, dim_row(4'b0100));   // timestamp wrapped
    push_word(OPC_MEASURE, 32'd150, '0);
    push_word(OPC_MEASURE, 32'd160, '1);
    push_word(OPC_CLEAR, '1, '1);
    push_word(OPC_MEASURE, 32'd5, dim_row(4'b0001));
    push_word(OPC_MEASURE, 32'hFFFF_FFFF, dim_row(4'b1000));
    push_cfg(REG_MARGIN, '0);
    push_cfg(REG_LIMIT, '0);
    push_cfg(REG_SPACING, 16'hFFFF);
    push_word(OPC_CALIB, '0, row4(900, 900, 900, 900));
    push_word(OPC_CALIB, '0, row4(900, 901, 900, 900));
    push_word(OPC_MEASURE, 32'd10, dim_row(4'b0001));
    push_word(OPC_MEASURE, 32'd11, dim_row(4'b0010));  // one ms at widest spacing
    push_cfg(REG_MARGIN, 16'd1023);
    push_cfg(REG_LIMIT, 16'd1023);
    push_cfg(REG_SPACING, '0);
    push_word(OPC_CALIB, '0, row4(0, 1023, 0, 1023));
    push_word(OPC_MEASURE, 32'd20, '0);

    clock_ms = 32'd1000;
    for (int p = 0; p < 10; p++) begin
      push_cfg(REG_MARGIN, pick_cfg(1023, 20, 250));
      push_cfg(REG_LIMIT, pick_cfg(1023, 0, 1023));
      push_cfg(REG_SPACING, pick_cfg(65535, 0, 65535));
      push_word(OPC_CALIB, clock_ms, calib_row());
      push_traffic(62);
      if (p % 3 == 1) push_drain();
      push_traffic(63);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (gate_words.size() > 150) @(posedge clk);
    calm = 1'b1;
    while (entries_done < total_entries || readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
